>>> rtl/fnpd_pkg.sv
// Shared types and constants for the fractional-N divider calculation block.
// Used by the controller, the datapath, the serial divider and the top level.
package fnpd_pkg;

  // Field widths
  localparam int REF_W      = 32;
  localparam int RDIV_W     = 10;
  localparam int FREQ_W     = 33;
  localparam int EXP_W      = 3;
  localparam int NINT_W     = 16;
  localparam int NFRAC_W    = 12;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Divider operand widths: the widest dividend is remainder times modulus
  localparam int DVD_W = FREQ_W + NFRAC_W;
  localparam int DVS_W = FREQ_W;

  // Largest output divider exponent
  localparam logic [EXP_W-1:0] MAX_DBL = EXP_W'(7);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REF_FREQ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLER  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_HALVER   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_R_DIV    = CFG_IDX_W'(3);

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = STAT_W'(0);
  localparam logic [STAT_W-1:0] STAT_PFD_ZERO = STAT_W'(1);
  localparam logic [STAT_W-1:0] STAT_OUT_LOW  = STAT_W'(2);
  localparam logic [STAT_W-1:0] STAT_INT_OVF = STAT_W'(3);

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PFD_GO,
    S_PFD_WAIT,
    S_DBL,
    S_NINT_GO,
    S_NINT_WAIT,
    S_NINT_CHK,
    S_MUL,
    S_FRAC_GO,
    S_FRAC_WAIT,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic pfd_start;
    logic pfd_take;
    logic dbl_step;
    logic nint_start;
    logic nint_take;
    logic mul;
    logic frac_start;
    logic frac_take;
    logic out_load;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic dbl_done;
    logic pfd_zero;
    logic vco_low;
    logic nint_ovf;
  } dp_status_t;

endpackage

>>> rtl/fnpd_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on fnpd_pkg for operand widths.
module fnpd_div import fnpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] dvs;

  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] trial;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem, quo[DVD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs};
  end

  // Control: busy flag, bit count, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[DVS_W+1]) begin
        rem <= trial[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

>>> rtl/fnpd_datapath.sv
// Datapath: configuration registers, doubling loop, operand routing into the
// shared serial divider, fraction multiply and the result register.
// Depends on fnpd_pkg and fnpd_div.
module fnpd_datapath import fnpd_pkg::*; #(
  parameter int unsigned FRAC_MODULUS = 4095,
  parameter int unsigned VCO_MIN_HZ   = 3000000000,
  parameter int unsigned PFD_MAX_HZ   = 140000000
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [FREQ_W-1:0]     out_freq_hz,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            stat,
  output logic [EXP_W-1:0]      out_div_log2,
  output logic [NINT_W-1:0]     n_integer,
  output logic [NFRAC_W-1:0]    n_fraction,
  output logic                  pfd_over_limit,
  output logic [STAT_W-1:0]     calc_status
);

  localparam logic [FREQ_W-1:0]  VCO_MIN  = FREQ_W'(VCO_MIN_HZ);
  localparam logic [FREQ_W-1:0]  PFD_MAX  = FREQ_W'(PFD_MAX_HZ);
  localparam logic [NFRAC_W-1:0] FRAC_MOD = NFRAC_W'(FRAC_MODULUS);

  // Configuration
  logic [REF_W-1:0]  ref_freq_hz;
  logic              ref_doubler_on;
  logic              ref_halver_on;
  logic [RDIV_W-1:0] ref_r_divider;

  // Working registers
  logic [FREQ_W-1:0]  vco;
  logic [EXP_W-1:0]   expo;
  logic [FREQ_W-1:0]  pfd;
  logic [NINT_W-1:0]  nint;
  logic               nint_ovf;
  logic [FREQ_W-1:0]  rem;
  logic [DVD_W-1:0]   prod;
  logic [NFRAC_W-1:0] nfrac;

  // Divider connection
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [DVS_W-1:0] div_rem;

  logic [FREQ_W-1:0] ref_scaled;
  logic [RDIV_W-1:0] r_eff;
  logic              vco_below;
  logic              pfd_zero;
  logic [STAT_W-1:0] res_status;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_freq_hz    <= '0;
      ref_doubler_on <= 1'b0;
      ref_halver_on  <= 1'b0;
      ref_r_divider  <= RDIV_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REF_FREQ: ref_freq_hz    <= cfg_data[REF_W-1:0];
        CFG_DOUBLER:  ref_doubler_on <= cfg_data[0];
        CFG_HALVER:   ref_halver_on  <= cfg_data[0];
        CFG_R_DIV:    ref_r_divider  <= cfg_data[RDIV_W-1:0];
        default:      ;
      endcase
    end
  end

  // Reference after doubler and halver, R of zero acts as one
  always_comb begin
    ref_scaled = ref_doubler_on ? {ref_freq_hz, 1'b0} : {1'b0, ref_freq_hz};
    if (ref_halver_on) begin
      ref_scaled = ref_scaled >> 1;
    end
    r_eff = (ref_r_divider == '0) ? RDIV_W'(1) : ref_r_divider;
  end

  assign vco_below = (vco < VCO_MIN);
  assign pfd_zero  = (pfd == '0);

  // Route divider operands for the current division
  always_comb begin
    div_start = cmd.pfd_start | cmd.nint_start | cmd.frac_start;
    div_dvd   = prod;
    div_dvs   = pfd;
    if (cmd.pfd_start) begin
      div_dvd = DVD_W'(ref_scaled);
      div_dvs = DVS_W'(r_eff);
    end else if (cmd.nint_start) begin
      div_dvd = DVD_W'(vco);
    end
  end

  fnpd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Capture input, double toward the VCO floor, form the fraction product and take division results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vco  <= out_freq_hz;
      expo <= '0;
    end else if (cmd.dbl_step && vco_below && expo != MAX_DBL) begin
      vco  <= {vco[FREQ_W-2:0], 1'b0};
      expo <= expo + EXP_W'(1);
    end
    if (cmd.pfd_take) begin
      pfd <= div_quo[FREQ_W-1:0];
    end
    if (cmd.nint_take) begin
      nint     <= div_quo[NINT_W-1:0];
      nint_ovf <= |div_quo[DVD_W-1:NINT_W];
      rem      <= div_rem;
    end
    if (cmd.mul) begin
      prod <= DVD_W'(rem) * DVD_W'(FRAC_MOD);
    end
    if (cmd.frac_take) begin
      nfrac <= div_quo[NFRAC_W-1:0];
    end
  end

  // Status toward the controller
  always_comb begin
    stat.div_done = div_done;
    stat.dbl_done = !vco_below || (expo == MAX_DBL);
    stat.pfd_zero = pfd_zero;
    stat.vco_low  = vco_below;
    stat.nint_ovf = nint_ovf;
  end

  // Final status with priority: zero comparison, too low, overflow
  always_comb begin
    if (pfd_zero) begin
      res_status = STAT_PFD_ZERO;
    end else if (vco_below) begin
      res_status = STAT_OUT_LOW;
    end else if (nint_ovf) begin
      res_status = STAT_INT_OVF;
    end else begin
      res_status = STAT_OK;
    end
  end

  // Result register, held until the next load
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      calc_status    <= res_status;
      pfd_over_limit <= (pfd > PFD_MAX);
      out_div_log2   <= (res_status == STAT_PFD_ZERO || res_status == STAT_OUT_LOW) ?
                        '0 : expo;
      n_integer      <= (res_status == STAT_OK) ? nint : '0;
      n_fraction     <= (res_status == STAT_OK) ? nfrac : '0;
    end
  end

endmodule

>>> rtl/fnpd_ctrl.sv
// Controller: sequences the comparison division, doubling, integer and
// fraction divisions, and owns the input stall and output valid.
// Depends on fnpd_pkg.
module fnpd_ctrl import fnpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid) state_next = S_PFD_GO;
      S_PFD_GO:    state_next = S_PFD_WAIT;
      S_PFD_WAIT:  if (stat.div_done) state_next = S_DBL;
      S_DBL: begin
        if (stat.dbl_done) begin
          if (stat.pfd_zero || stat.vco_low) begin
            state_next = S_DONE;
          end else begin
            state_next = S_NINT_GO;
          end
        end
      end
      S_NINT_GO:   state_next = S_NINT_WAIT;
      S_NINT_WAIT: if (stat.div_done) state_next = S_NINT_CHK;
      S_NINT_CHK:  state_next = stat.nint_ovf ? S_DONE : S_MUL;
      S_MUL:       state_next = S_FRAC_GO;
      S_FRAC_GO:   state_next = S_FRAC_WAIT;
      S_FRAC_WAIT: if (stat.div_done) state_next = S_DONE;
      S_DONE:      if (slot_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd      = '0;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE:      cmd.load       = in_valid;
      S_PFD_GO:    cmd.pfd_start  = 1'b1;
      S_PFD_WAIT:  cmd.pfd_take   = stat.div_done;
      S_DBL:       cmd.dbl_step   = 1'b1;
      S_NINT_GO:   cmd.nint_start = 1'b1;
      S_NINT_WAIT: cmd.nint_take  = stat.div_done;
      S_MUL:       cmd.mul        = 1'b1;
      S_FRAC_GO:   cmd.frac_start = 1'b1;
      S_FRAC_WAIT: cmd.frac_take  = stat.div_done;
      S_DONE:      cmd.out_load   = slot_free;
      default:     ;
    endcase
  end

  // Output valid: set on load, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/frac_n_pll_divider_calc_unit.sv
// Top level of the fractional-N divider calculation block.
// Depends on fnpd_pkg, fnpd_ctrl and fnpd_datapath.
//
//   channel  handshake              payload
//   -------  ---------------------  ---------------------------------------------
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//   in       in_valid / in_stall    out_freq_hz
//   out      out_valid / out_stall  out_div_log2, n_integer, n_fraction,
//                                   pfd_over_limit, calc_status
//
// An item makes three passes of the shared serial divider at one quotient bit
// per cycle, each with a start and a take, plus the doubling loop. Error cases
// end earlier: a zero comparison or too-low output after the doubling loop,
// an integer overflow after the integer division.
// Reset clears the controller and output valid and loads the register
// defaults. One result waits in the output register while the next item is
// accepted and computed; a finished item waits until that register is free.
module frac_n_pll_divider_calc_unit import fnpd_pkg::*; #(
  parameter int unsigned FRAC_MODULUS = 4095,
  parameter int unsigned VCO_MIN_HZ   = 3000000000,
  parameter int unsigned PFD_MAX_HZ   = 140000000
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FREQ_W-1:0]     out_freq_hz,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [EXP_W-1:0]      out_div_log2,
  output logic [NINT_W-1:0]     n_integer,
  output logic [NFRAC_W-1:0]    n_fraction,
  output logic                  pfd_over_limit,
  output logic [STAT_W-1:0]     calc_status
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  // Registers take a write in any cycle
  assign cfg_ready = 1'b1;

  fnpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fnpd_datapath #(
    .FRAC_MODULUS (FRAC_MODULUS),
    .VCO_MIN_HZ   (VCO_MIN_HZ),
    .PFD_MAX_HZ   (PFD_MAX_HZ)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_freq_hz    (out_freq_hz),
    .cmd            (cmd),
    .stat           (stat),
    .out_div_log2   (out_div_log2),
    .n_integer      (n_integer),
    .n_fraction     (n_fraction),
    .pfd_over_limit (pfd_over_limit),
    .calc_status    (calc_status)
  );

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Testbench for frac_n_pll_divider_calc_unit: a directed table, then random frequency
// requests under many reference settings and idle patterns, checked by a local calculator.
// Depends on fnpd_pkg and the RTL top level.
module tb;
  import fnpd_pkg::*;

  localparam logic [63:0] VCO_FLOOR_HZ = 64'd3000000000;
  localparam logic [63:0] PFD_LIMIT_HZ = 64'd140000000;
  localparam logic [63:0] FRAC_MOD     = 64'd4095;
  localparam logic [63:0] NINT_LIMIT   = 64'd65535;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int PRESSURE_PHASE  = 2;
  localparam int HOLD_CYCLES     = 1500;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int DRAIN_CYCLES    = 300;

  typedef struct packed {
    logic [EXP_W-1:0]   dbl_exp;
    logic [NINT_W-1:0]  nint;
    logic [NFRAC_W-1:0] nfrac;
    logic               over;
    logic [STAT_W-1:0]  status;
  } divset_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [FREQ_W-1:0]     freq;
    logic                  typed;
    divset_t               want;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [FREQ_W-1:0]     out_freq_hz;
  logic                  out_valid;
  logic                  out_stall;
  logic [EXP_W-1:0]      out_div_log2;
  logic [NINT_W-1:0]     n_integer;
  logic [NFRAC_W-1:0]    n_fraction;
  logic                  pfd_over_limit;
  logic [STAT_W-1:0]     calc_status;

  // Local copy of the reference settings
  logic [REF_W-1:0]  cur_ref_hz;
  logic              cur_doubler;
  logic              cur_halver;
  logic [RDIV_W-1:0] cur_rdiv;

  divset_t     pending_settings[$];
  plan_row_t   plan[$];
  int unsigned snd_idle_pct;
  int unsigned rcv_stall_pct;
  logic        hold_on;
  int          err_count;
  int          quiet_cycles;
  divset_t     result_seen;
  divset_t     result_due;

  frac_n_pll_divider_calc_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_freq_hz    (out_freq_hz),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_div_log2   (out_div_log2),
    .n_integer      (n_integer),
    .n_fraction     (n_fraction),
    .pfd_over_limit (pfd_over_limit),
    .calc_status    (calc_status)
  );

  always #5 clk = ~clk;

  // Divider settings for one requested frequency under the current reference setup
  function automatic divset_t calc_divider_settings(input logic [FREQ_W-1:0] f);
    logic [63:0] pfd;
    logic [63:0] rdiv;
    logic [63:0] vco;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] frac;
    int          k;
    divset_t     r;
    pfd = 64'(cur_ref_hz);
    if (cur_doubler) pfd = pfd << 1;
    if (cur_halver) pfd = pfd >> 1;
    // R of zero divides by one
    rdiv = (cur_rdiv == '0) ? 64'd1 : 64'(cur_rdiv);
    pfd = pfd / rdiv;
    vco = 64'(f);
    k = 0;
    while (vco < VCO_FLOOR_HZ && k < int'(MAX_DBL)) begin
      vco = vco << 1;
      k++;
    end
    r = '0;
    r.over = (pfd > PFD_LIMIT_HZ);
    if (pfd == 64'd0) begin
      r.status = STAT_PFD_ZERO;
    end else if (vco < VCO_FLOOR_HZ) begin
      r.status = STAT_OUT_LOW;
    end else begin
      r.dbl_exp = k[EXP_W-1:0];
      quo = vco / pfd;
      if (quo > NINT_LIMIT) begin
        r.status = STAT_INT_OVF;
      end else begin
        rem = vco - quo * pfd;
        frac = rem * FRAC_MOD / pfd;
        r.nint = quo[NINT_W-1:0];
        r.nfrac = frac[NFRAC_W-1:0];
        r.status = STAT_OK;
      end
    end
    return r;
  endfunction

  function automatic divset_t known(input int e, input int ni, input int nf, input bit ov,
                                    input logic [STAT_W-1:0] st);
    divset_t r;
    r.dbl_exp = e[EXP_W-1:0];
    r.nint = ni[NINT_W-1:0];
    r.nfrac = nf[NFRAC_W-1:0];
    r.over = ov;
    r.status = st;
    return r;
  endfunction

  function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    plan.push_back(r);
  endfunction

  function automatic void row_item(input logic [FREQ_W-1:0] f, input logic typed,
                                   input divset_t want);
    plan_row_t r;
    r = '0;
    r.freq = f;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endfunction

  // Requested frequency: mostly inside the doubling bands, some near the band
  // edges, some too low, and some anywhere in the 33-bit range
  function automatic logic [FREQ_W-1:0] pick_out_freq();
    int unsigned sel;
    int unsigned k;
    logic [63:0] base;
    logic [63:0] f;
    sel = $urandom_range(99);
    k = $urandom_range(7);
    base = VCO_FLOOR_HZ >> k;
    if (sel < 50) f = base + (64'($urandom) % base);
    else if (sel < 65) f = {31'd0, 1'($urandom_range(1)), $urandom};
    else if (sel < 75) f = ((VCO_FLOOR_HZ + (64'd1 << k) - 64'd1) >> k)
                           + 64'($urandom_range(2)) - 64'd1;
    else if (sel < 85) f = 64'($urandom_range(23437499));
    else if (sel < 90) f = 64'd0;
    else f = 64'd6000000000 + (64'($urandom) % 64'd2589934592);
    return f[FREQ_W-1:0];
  endfunction

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Write one register once the block has returned every pending result
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    while (pending_settings.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_REF_FREQ: cur_ref_hz = data;
      CFG_DOUBLER:  cur_doubler = data[0];
      CFG_HALVER:   cur_halver = data[0];
      CFG_R_DIV:    cur_rdiv = data[RDIV_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offer one frequency, with random idle cycles ahead of it; queue its expectation
  task automatic send_freq(input logic [FREQ_W-1:0] f, input logic typed, input divset_t want);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    out_freq_hz <= f;
    do @(posedge clk); while (!(in_valid && !in_stall));
    pending_settings.push_back(typed ? want : calc_divider_settings(f));
  endtask

  task automatic quiet_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_random_batch(input int n);
    for (int i = 0; i < n; i++) send_freq(pick_out_freq(), 1'b0, '0);
  endtask

  task automatic randomize_settings();
    int unsigned           sel;
    logic [CFG_DATA_W-1:0] ref_hz;
    logic [RDIV_W-1:0]     rdiv;
    sel = $urandom_range(99);
    if (sel < 65) begin
      ref_hz = $urandom_range(400000000, 1000000);
      rdiv = RDIV_W'($urandom_range(4, 1));
    end else if (sel < 80) begin
      ref_hz = $urandom;
      rdiv = RDIV_W'($urandom_range(1023, 1));
    end else if (sel < 90) begin
      ref_hz = $urandom_range(200000, 1000);
      rdiv = RDIV_W'(1);
    end else begin
      ref_hz = $urandom_range(2000);
      rdiv = RDIV_W'($urandom_range(1023));
    end
    cfg_write(CFG_REF_FREQ, ref_hz);
    cfg_write(CFG_DOUBLER, $urandom);
    cfg_write(CFG_HALVER, $urandom);
    cfg_write(CFG_R_DIV, ($urandom & ~32'h3FF) | 32'(rdiv));
    // Unmapped index now and then; it must leave the setup alone
    if ($urandom_range(3) == 0) cfg_write(CFG_IDX_W'($urandom_range(255, 4)), $urandom);
  endtask

  task automatic set_idling(input int unsigned snd, input int unsigned rcv);
    @(posedge clk);
    snd_idle_pct = snd;
    rcv_stall_pct = rcv;
  endtask

  // Receiver stalls: random, or held for a long stretch
  always @(negedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < rcv_stall_pct);
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      result_seen = '{out_div_log2, n_integer, n_fraction, pfd_over_limit, calc_status};
      if (pending_settings.size() == 0) begin
        report_err($sformatf("result with nothing pending: %p", result_seen));
      end else begin
        result_due = pending_settings.pop_front();
        if (result_seen.dbl_exp !== result_due.dbl_exp)
          report_err($sformatf("out_div_log2 got %0d want %0d",
                               result_seen.dbl_exp, result_due.dbl_exp));
        if (result_seen.nint !== result_due.nint)
          report_err($sformatf("n_integer got %0d want %0d",
                               result_seen.nint, result_due.nint));
        if (result_seen.nfrac !== result_due.nfrac)
          report_err($sformatf("n_fraction got %0d want %0d",
                               result_seen.nfrac, result_due.nfrac));
        if (result_seen.over !== result_due.over)
          report_err($sformatf("pfd_over_limit got %0d want %0d",
                               result_seen.over, result_due.over));
        if (result_seen.status !== result_due.status)
          report_err($sformatf("calc_status got %0d want %0d",
                               result_seen.status, result_due.status));
      end
    end
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    out_freq_hz = '0;
    out_stall = 1'b0;
    hold_on = 1'b0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    err_count = 0;
    quiet_cycles = 0;
    cur_ref_hz = '0;
    cur_doubler = 1'b0;
    cur_halver = 1'b0;
    cur_rdiv = RDIV_W'(1);

    // Reset values leave the comparison frequency at zero
    row_item(33'd3000000000, 1'b1, known(0, 0, 0, 0, STAT_PFD_ZERO));
    row_item(33'd0, 1'b1, known(0, 0, 0, 0, STAT_PFD_ZERO));
    // 100 MHz comparison: band edges, zero and the top of the range
    row_cfg(CFG_REF_FREQ, 32'd100000000);
    row_cfg(CFG_R_DIV, 32'd1);
    row_item(33'd0, 1'b1, known(0, 0, 0, 0, STAT_OUT_LOW));
    row_item(33'd1, 1'b1, known(0, 0, 0, 0, STAT_OUT_LOW));
    row_item(33'd3000000000, 1'b1, known(0, 30, 0, 0, STAT_OK));
    row_item(33'd1500000000, 1'b1, known(1, 30, 0, 0, STAT_OK));
    row_item(33'd23437500, 1'b1, known(7, 30, 0, 0, STAT_OK));
    row_item(33'd23437499, 1'b1, known(0, 0, 0, 0, STAT_OUT_LOW));
    row_item(33'd2999999999, 1'b0, '0);
    row_item(33'h1_FFFF_FFFF, 1'b0, '0);
    // Integer divide right at and just past its 16-bit limit
    row_cfg(CFG_REF_FREQ, 32'd100000);
    row_item(33'd6553500000, 1'b1, known(0, 65535, 0, 0, STAT_OK));
    row_item(33'd6553600000, 1'b1, known(0, 0, 0, 0, STAT_INT_OVF));
    row_item(33'd23437500, 1'b1, known(7, 30000, 0, 0, STAT_OK));
    row_cfg(CFG_REF_FREQ, 32'd1000);
    row_item(33'd23437500, 1'b1, known(7, 0, 0, 0, STAT_INT_OVF));
    // Largest reference, doubled past 32 bits, then the largest R
    row_cfg(CFG_REF_FREQ, 32'hFFFF_FFFF);
    row_cfg(CFG_DOUBLER, 32'd1);
    row_item(33'd3000000000, 1'b0, '0);
    row_item(33'h1_FFFF_FFFF, 1'b0, '0);
    row_cfg(CFG_R_DIV, 32'd1023);
    row_item(33'd4000000000, 1'b0, '0);
    // Reference divided down to nothing
    row_cfg(CFG_REF_FREQ, 32'd1);
    row_cfg(CFG_DOUBLER, 32'd0);
    row_item(33'd5000000000, 1'b1, known(0, 0, 0, 0, STAT_PFD_ZERO));
    // Doubler and halver together, R of zero, stray upper data bits, unmapped indexes
    row_cfg(CFG_REF_FREQ, 32'd200000001);
    row_cfg(CFG_DOUBLER, 32'hFFFF_FFFF);
    row_cfg(CFG_HALVER, 32'h8000_0001);
    row_cfg(CFG_R_DIV, 32'hFFFF_FC00);
    row_cfg(8'hFF, 32'h5A5A_5A5A);
    row_cfg(8'd4, 32'd7);
    row_item(33'd3000000000, 1'b0, '0);
    // Halved reference exactly at the comparison limit, then just over it
    row_cfg(CFG_DOUBLER, 32'd0);
    row_cfg(CFG_REF_FREQ, 32'd280000001);
    row_item(33'd3000000000, 1'b0, '0);
    row_cfg(CFG_REF_FREQ, 32'd280000003);
    row_item(33'd3000000000, 1'b0, '0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    set_idling(11, 11);
    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) begin
        cfg_write(plan[i].idx, plan[i].data);
      end else begin
        send_freq(plan[i].freq, plan[i].typed, plan[i].want);
        if (i == plan.size() - 1 || plan[i + 1].is_cfg) quiet_input();
      end
    end

    // Random phases, each with a fresh reference setup and idle pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      randomize_settings();
      case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(86, 0);
        2: set_idling(0, 86);
        default: set_idling(11, 11);
      endcase
      if (p == PRESSURE_PHASE) begin
        set_idling(0, 0);
        fork
          begin
            @(posedge clk);
            hold_on = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on = 1'b0;
          end
          send_random_batch(ITEMS_PER_PHASE);
        join
      end else begin
        send_random_batch(ITEMS_PER_PHASE);
      end
      quiet_input();
    end

    // Drain, then give the block time to show any extra result
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
